FILE: rtl/bezier_distance_to_parameter_macros.svh
// Assertion macros shared by the distance-to-parameter RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef BEZIER_DISTANCE_TO_PARAMETER_MACROS_SVH
`define BEZIER_DISTANCE_TO_PARAMETER_MACROS_SVH

// Same-cycle implication under asynchronous active-low reset.
`define BDTP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bdtp assertion failed");

// Next-cycle implication under asynchronous active-low reset.
`define BDTP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bdtp assertion failed");

`endif

FILE: rtl/bdtp_pkg.sv
// Shared types, codes and helpers for the distance-to-parameter block.
// Used by bdtp_alu and bezier_distance_to_parameter; no dependencies.
`default_nettype none

package bdtp_pkg;

	typedef logic signed [63:0] word_t;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
		word_t   a;
		word_t   b;
	} alu_req_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_LIN_DIV,
		S_ARC_INIT,
		S_DRV_START,
		S_DRV_W0,
		S_DRV_W2,
		S_DRV_P,
		S_DRV_C,
		S_DRV_SQ,
		S_DRV_RT,
		S_RB_L0,
		S_RB_LV,
		S_RB_J,
		S_RB_END,
		S_NT_INIT,
		S_NT_CHECK,
		S_NT_DIV,
		S_PT_U2,
		S_PT_T2,
		S_PT_B,
		S_PT_MUL,
		S_PT_AX
	} state_t;

	// Register map indexes
	localparam logic [2:0] REG_START   = 3'd0;
	localparam logic [2:0] REG_OUT_CP  = 3'd1;
	localparam logic [2:0] REG_IN_CP   = 3'd2;
	localparam logic [2:0] REG_END     = 3'd3;
	localparam logic [2:0] REG_MODE    = 3'd4;
	localparam logic [2:0] REG_SEGLEN  = 3'd5;

	// Result status codes
	localparam logic [1:0] ST_CONV  = 2'd0;
	localparam logic [1:0] ST_LIMIT = 2'd1;
	localparam logic [1:0] ST_SAT   = 2'd2;

	localparam word_t ONE_Q16   = 64'sd65536;
	localparam word_t ONE_Q32   = 64'sd4294967296;
	localparam word_t TOL_FX    = 64'sd1073742;
	localparam logic [16:0] T_ONE = 17'h10000;

	localparam int DEF_ROMBERG_ORDER    = 5;
	localparam int DEF_MAX_NEWTON_STEPS = 10;
	localparam int DEF_COORD_BITS       = 21;

	// Divide by 2^k, rounding half away from zero (k >= 1)
	function automatic word_t rnd_shr(word_t n, logic [5:0] k);
		word_t m;
		word_t h;
		m = (n < 0) ? -n : n;
		h = 64'sd1 <<< (k - 6'd1);
		m = (m + h) >>> k;
		return (n < 0) ? -m : m;
	endfunction

	function automatic word_t zx17(logic [16:0] v);
		return {47'd0, v};
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bdtp_alu.sv
// Shared iterative arithmetic unit: serial multiply, rounding divide, square root.
// Depends on bdtp_pkg and the assertion macro header.
`default_nettype none

`include "bezier_distance_to_parameter_macros.svh"

module bdtp_alu (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bdtp_pkg::alu_req_t req,
	output logic                  done,
	output bdtp_pkg::word_t       res
);
	import bdtp_pkg::*;

	logic        busy_q;
	logic        done_q;
	alu_op_t     op_q;
	logic        neg_q;
	logic [63:0] x_q;
	logic [63:0] y_q;
	logic [63:0] z_q;
	logic [5:0]  cnt_q;
	logic [63:0] res_q;

	logic [63:0] mul_x;
	logic [63:0] div_rsh;
	logic        div_ge;
	logic [63:0] div_x;
	logic [63:0] div_y;
	logic [63:0] sq_sum;
	logic        sq_ge;
	logic [63:0] sq_x;
	logic [63:0] sq_y;
	logic        fin;
	logic [63:0] fin_val;

	// One step of each operation
	always_comb begin
		mul_x   = z_q[0] ? x_q + y_q : x_q;
		div_rsh = {x_q[62:0], y_q[63]};
		div_ge  = div_rsh >= z_q;
		div_x   = div_ge ? div_rsh - z_q : div_rsh;
		div_y   = {y_q[62:0], div_ge};
		sq_sum  = x_q + z_q;
		sq_ge   = y_q >= sq_sum;
		sq_y    = sq_ge ? y_q - sq_sum : y_q;
		sq_x    = sq_ge ? (x_q >> 1) + z_q : x_q >> 1;
	end

	// Finish condition and final value
	always_comb begin
		case (op_q)
			ALU_MUL: begin
				fin     = z_q == 64'd0;
				fin_val = neg_q ? -x_q : x_q;
			end
			ALU_DIV: begin
				fin     = cnt_q == 6'd0;
				fin_val = neg_q ? -div_y : div_y;
			end
			ALU_SQRT: begin
				fin     = cnt_q == 6'd0;
				fin_val = sq_x;
			end
			default: begin
				fin     = 1'b1;
				fin_val = 64'd0;
			end
		endcase
	end

	// Control: busy and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= ALU_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
			end else if (busy_q && fin) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: load operands, then advance one step a cycle
	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			x_q <= 64'd0;
			case (req.op)
				ALU_MUL: begin
					y_q   <= req.a;
					z_q   <= (req.b < 0) ? -req.b : req.b;
					neg_q <= req.b < 0;
					cnt_q <= 6'd0;
				end
				ALU_DIV: begin
					y_q   <= ((req.a < 0) ? -req.a : req.a) + (req.b >>> 1);
					z_q   <= req.b;
					neg_q <= req.a < 0;
					cnt_q <= 6'd63;
				end
				ALU_SQRT: begin
					y_q   <= req.a;
					z_q   <= 64'd1 << 62;
					neg_q <= 1'b0;
					cnt_q <= 6'd31;
				end
				default: begin
					y_q   <= 64'd0;
					z_q   <= 64'd0;
					neg_q <= 1'b0;
					cnt_q <= 6'd0;
				end
			endcase
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (fin)
				res_q <= fin_val;
			case (op_q)
				ALU_MUL: begin
					x_q <= mul_x;
					y_q <= y_q << 1;
					z_q <= z_q >> 1;
				end
				ALU_DIV: begin
					x_q <= div_x;
					y_q <= div_y;
				end
				ALU_SQRT: begin
					x_q <= sq_x;
					y_q <= sq_y;
					z_q <= z_q >> 2;
				end
				default: begin
					x_q <= x_q;
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = signed'(res_q);

	`BDTP_ASSERT_IMP(a_no_start_busy, clk, arst_n, req.start, !busy_q)
	`BDTP_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, !busy_q)
	`BDTP_ASSERT_NXT(a_done_pulse, clk, arst_n, done_q, !done_q)

endmodule

`default_nettype wire

FILE: rtl/bezier_distance_to_parameter.sv
// Cubic Bezier distance-to-parameter unit: Newton search on a Romberg arc length.
// Depends on bdtp_pkg, bdtp_alu and the assertion macro header.
//
//  port group   direction  handshake
//  config       in/out     APB write at psel & penable & pwrite & pready
//  distance     in         accepted when start & !busy
//  result       out        done strobe, one cycle, no back-pressure
//
// Every multiply, divide and square root goes through the one bdtp_alu.
// Multiply retires one multiplier bit per step, divide one quotient bit, root one result bit.
// One arc-length integral takes 17 derivative samples at the default Romberg order.
// busy is high from acceptance until the done strobe; reset clears control and configuration only.
`default_nettype none

`include "bezier_distance_to_parameter_macros.svh"

module bezier_distance_to_parameter #(
	parameter int ROMBERG_ORDER    = bdtp_pkg::DEF_ROMBERG_ORDER,
	parameter int MAX_NEWTON_STEPS = bdtp_pkg::DEF_MAX_NEWTON_STEPS,
	parameter int COORD_BITS       = bdtp_pkg::DEF_COORD_BITS
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [5:0]         paddr,
	input  wire logic [63:0]        pwdata,
	output logic [63:0]             prdata,
	output logic                    pready,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [18:0]        distance,
	output logic                    done,
	output logic [16:0]             param_t,
	output logic signed [20:0]      point_x,
	output logic signed [20:0]      point_y,
	output logic signed [20:0]      point_z,
	output logic [1:0]              status
);
	import bdtp_pkg::*;

	localparam int NSEG = 1 << (ROMBERG_ORDER - 1);
	localparam int NSH  = ROMBERG_ORDER - 1;
	localparam int KW   = $clog2(NSEG + 1);
	localparam int LW   = $clog2(ROMBERG_ORDER);
	localparam int IW   = $clog2(MAX_NEWTON_STEPS + 1);
	localparam int BKW  = 17 + KW;

	// ---------------- configuration registers ----------------
	logic [62:0] pts_q [4];
	logic        mode_q;
	logic [18:0] seglen_q;
	logic        wr_en;
	logic [2:0]  widx;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign widx   = paddr[5:3];

	// Hold register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++)
				pts_q[i] <= 63'd0;
			mode_q   <= 1'b0;
			seglen_q <= 19'd1;
		end else if (wr_en) begin
			case (widx)
				REG_START:  pts_q[0] <= pwdata[62:0];
				REG_OUT_CP: pts_q[1] <= pwdata[62:0];
				REG_IN_CP:  pts_q[2] <= pwdata[62:0];
				REG_END:    pts_q[3] <= pwdata[62:0];
				REG_MODE:   mode_q   <= pwdata[0];
				REG_SEGLEN: seglen_q <= pwdata[18:0];
				default:    mode_q   <= mode_q;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (widx)
			REG_START:  prdata = {1'b0, pts_q[0]};
			REG_OUT_CP: prdata = {1'b0, pts_q[1]};
			REG_IN_CP:  prdata = {1'b0, pts_q[2]};
			REG_END:    prdata = {1'b0, pts_q[3]};
			REG_MODE:   prdata = {63'd0, mode_q};
			REG_SEGLEN: prdata = {45'd0, seglen_q};
			default:    prdata = 64'd0;
		endcase
	end

	// ---------------- coordinates ----------------
	function automatic word_t coord_of(logic [62:0] r, int axis);
		logic [COORD_BITS-1:0] c;
		c = r[21*axis +: COORD_BITS];
		return {{(64-COORD_BITS){c[COORD_BITS-1]}}, c};
	endfunction

	function automatic word_t sat_coord(word_t v);
		word_t hi;
		word_t lo;
		hi = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
		lo = -(64'sd1 <<< (COORD_BITS - 1));
		return (v > hi) ? hi : ((v < lo) ? lo : v);
	endfunction

	function automatic logic [17:0] clamp_t(word_t v);
		if (v < 0)
			return {1'b1, 17'd0};
		if (v > ONE_Q16)
			return {1'b1, T_ONE};
		return {1'b0, v[16:0]};
	endfunction

	word_t cp [4][3];
	word_t dd [3][3];

	always_comb begin
		for (int i = 0; i < 4; i++)
			for (int a = 0; a < 3; a++)
				cp[i][a] = coord_of(pts_q[i], a);
		for (int i = 0; i < 3; i++)
			for (int a = 0; a < 3; a++)
				dd[i][a] = cp[i+1][a] - cp[i][a];
	end

	// ---------------- sequencer state ----------------
	state_t       state_q, state_d;
	logic         issued_q;
	logic [18:0]  dist_q;
	logic         phase_q;
	logic [16:0]  b_q;
	logic [KW-1:0] k_q;
	logic [BKW-1:0] bk_q;
	logic [16:0]  tk_q;
	word_t        w0_q, w1_q, w2_q;
	logic [1:0]   di_q;
	logic [1:0]   axis_q;
	word_t        acc_q;
	word_t        c_q;
	word_t        sq_q;
	word_t        ends_q;
	word_t        inner_q [1:ROMBERG_ORDER-1];
	word_t        mlast_q;
	logic [LW-1:0] lv_q;
	logic [LW-1:0] j_q;
	word_t        last_q;
	word_t        prev_q [ROMBERG_ORDER];
	word_t        total_q;
	word_t        diff_q;
	logic [16:0]  t_q;
	logic         sat_q;
	logic [IW-1:0] it_q;
	word_t        blend_q [4];
	logic [1:0]   pi_q;
	logic [20:0]  pt_q [3];
	logic [1:0]   status_q;
	logic         done_q;

	alu_req_t     req;
	logic         alu_done;
	word_t        alu_res;
	logic         alu_use;
	alu_op_t      alu_op;
	word_t        alu_a, alu_b;

	bdtp_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.done   (alu_done),
		.res    (alu_res)
	);

	// Helper values
	logic [BKW:0] bk_rnd;
	logic [16:0]  tk_next;
	word_t        u_k, u_t, sfx, seg_div, m_div, wsel;
	logic [17:0]  cl_lin, cl_nt, cl_new;
	logic         last_lv, last_it, conv;
	word_t        pt_round;

	always_comb begin
		bk_rnd  = {1'b0, bk_q} + (BKW+1)'(NSEG / 2);
		tk_next = bk_rnd[NSH +: 17];
		u_k     = ONE_Q16 - zx17(tk_q);
		u_t     = ONE_Q16 - zx17(t_q);
		sfx     = {25'd0, dist_q, 20'd0};
		seg_div = (seglen_q == 19'd0) ? 64'sd1 : {45'd0, seglen_q};
		m_div   = (mlast_q == 64'sd0) ? 64'sd1 : mlast_q;
		cl_lin  = clamp_t(alu_res);
		cl_nt   = clamp_t(alu_res);
		cl_new  = clamp_t(zx17(t_q) - alu_res);
		last_lv = lv_q == LW'(ROMBERG_ORDER - 1);
		last_it = it_q == IW'(MAX_NEWTON_STEPS - 1);
		conv    = (diff_q < TOL_FX) && (diff_q > -TOL_FX);
		pt_round = sat_coord(rnd_shr(acc_q, 6'd32));
		case (di_q)
			2'd0:    wsel = w0_q;
			2'd1:    wsel = w1_q;
			default: wsel = w2_q;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:      if (start) state_d = mode_q ? S_ARC_INIT : S_LIN_DIV;
			S_LIN_DIV:   if (alu_done) state_d = S_PT_MUL;
			S_ARC_INIT:  state_d = S_DRV_START;
			S_DRV_START: state_d = S_DRV_W0;
			S_DRV_W0:    if (alu_done) state_d = S_DRV_W2;
			S_DRV_W2:    if (alu_done) state_d = S_DRV_P;
			S_DRV_P:     if (alu_done && di_q == 2'd2) state_d = S_DRV_C;
			S_DRV_C:     state_d = S_DRV_SQ;
			S_DRV_SQ:    if (alu_done) state_d = (axis_q == 2'd2) ? S_DRV_RT : S_DRV_P;
			S_DRV_RT: begin
				if (alu_done)
					state_d = (k_q == KW'(NSEG)) ? S_RB_L0 : S_DRV_START;
			end
			S_RB_L0:     if (alu_done) state_d = S_RB_LV;
			S_RB_LV:     if (alu_done) state_d = S_RB_J;
			S_RB_J:      if (alu_done && j_q == lv_q) state_d = S_RB_END;
			S_RB_END: begin
				if (!last_lv)
					state_d = S_RB_LV;
				else if (phase_q)
					state_d = S_NT_CHECK;
				else
					state_d = (last_q <= 0) ? S_PT_U2 : S_NT_INIT;
			end
			S_NT_INIT:   if (alu_done) state_d = S_ARC_INIT;
			S_NT_CHECK:  state_d = conv ? S_PT_U2 : S_NT_DIV;
			S_NT_DIV:    if (alu_done) state_d = last_it ? S_PT_U2 : S_ARC_INIT;
			S_PT_U2:     if (alu_done) state_d = S_PT_T2;
			S_PT_T2:     if (alu_done) state_d = S_PT_B;
			S_PT_B:      if (alu_done && pi_q == 2'd3) state_d = S_PT_MUL;
			S_PT_MUL:    if (alu_done && pi_q == 2'd3) state_d = S_PT_AX;
			S_PT_AX:     state_d = (axis_q == 2'd2) ? S_IDLE : S_PT_MUL;
			default:     state_d = S_IDLE;
		endcase
	end

	// Outputs: arithmetic request for the current step
	always_comb begin
		alu_use = 1'b1;
		alu_op  = ALU_MUL;
		alu_a   = 64'sd0;
		alu_b   = 64'sd0;
		case (state_q)
			S_LIN_DIV: begin
				alu_op = ALU_DIV;
				alu_a  = {29'd0, dist_q, 16'd0};
				alu_b  = seg_div;
			end
			S_DRV_W0: begin
				alu_a = u_k;
				alu_b = u_k;
			end
			S_DRV_W2: begin
				alu_a = zx17(tk_q);
				alu_b = zx17(tk_q);
			end
			S_DRV_P: begin
				alu_a = wsel;
				alu_b = dd[di_q][axis_q];
			end
			S_DRV_SQ: begin
				alu_a = c_q;
				alu_b = c_q;
			end
			S_DRV_RT: begin
				alu_op = ALU_SQRT;
				alu_a  = sq_q;
			end
			S_RB_L0: begin
				alu_a = ends_q;
				alu_b = zx17(b_q);
			end
			S_RB_LV: begin
				alu_a = ends_q + (inner_q[lv_q] <<< 1);
				alu_b = zx17(b_q);
			end
			S_RB_J: begin
				alu_op = ALU_DIV;
				alu_a  = (last_q <<< {j_q, 1'b0}) - prev_q[j_q - LW'(1)];
				alu_b  = (64'sd1 <<< {j_q, 1'b0}) - 64'sd1;
			end
			S_NT_INIT: begin
				alu_op = ALU_DIV;
				alu_a  = sfx <<< 16;
				alu_b  = total_q;
			end
			S_NT_DIV: begin
				alu_op = ALU_DIV;
				alu_a  = diff_q;
				alu_b  = m_div;
			end
			S_PT_U2: begin
				alu_a = u_t;
				alu_b = u_t;
			end
			S_PT_T2: begin
				alu_a = zx17(t_q);
				alu_b = zx17(t_q);
			end
			S_PT_B: begin
				case (pi_q)
					2'd0: begin
						alu_a = w0_q;
						alu_b = u_t;
					end
					2'd1: begin
						alu_a = w0_q + (w0_q <<< 1);
						alu_b = zx17(t_q);
					end
					2'd2: begin
						alu_a = w2_q + (w2_q <<< 1);
						alu_b = u_t;
					end
					default: begin
						alu_a = w2_q;
						alu_b = zx17(t_q);
					end
				endcase
			end
			S_PT_MUL: begin
				alu_a = blend_q[pi_q];
				alu_b = cp[pi_q][axis_q];
			end
			default: alu_use = 1'b0;
		endcase
		req.start = alu_use && !issued_q;
		req.op    = alu_op;
		req.a     = alu_a;
		req.b     = alu_b;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			issued_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_PT_AX) && (axis_q == 2'd2);
			if (alu_done)
				issued_q <= 1'b0;
			else if (req.start)
				issued_q <= 1'b1;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					dist_q  <= distance;
					sat_q   <= 1'b0;
					it_q    <= '0;
					b_q     <= T_ONE;
					phase_q <= 1'b0;
				end
			end
			S_LIN_DIV: begin
				if (alu_done) begin
					t_q        <= cl_lin[16:0];
					sat_q      <= cl_lin[17];
					status_q   <= cl_lin[17] ? ST_SAT : ST_CONV;
					blend_q[0] <= (ONE_Q16 - zx17(cl_lin[16:0])) <<< 16;
					blend_q[1] <= 64'sd0;
					blend_q[2] <= 64'sd0;
					blend_q[3] <= zx17(cl_lin[16:0]) <<< 16;
					pi_q       <= 2'd0;
					axis_q     <= 2'd0;
					acc_q      <= 64'sd0;
				end
			end
			S_ARC_INIT: begin
				k_q    <= '0;
				bk_q   <= '0;
				ends_q <= 64'sd0;
				for (int l = 1; l < ROMBERG_ORDER; l++)
					inner_q[l] <= 64'sd0;
			end
			S_DRV_START: begin
				tk_q   <= tk_next;
				axis_q <= 2'd0;
				di_q   <= 2'd0;
				acc_q  <= 64'sd0;
				sq_q   <= 64'sd0;
			end
			S_DRV_W0: if (alu_done) w0_q <= alu_res;
			S_DRV_W2: begin
				if (alu_done) begin
					w2_q <= alu_res;
					w1_q <= ONE_Q32 - w0_q - alu_res;
				end
			end
			S_DRV_P: begin
				if (alu_done) begin
					acc_q <= acc_q + alu_res;
					di_q  <= (di_q == 2'd2) ? 2'd0 : di_q + 2'd1;
				end
			end
			S_DRV_C: c_q <= rnd_shr(acc_q + (acc_q <<< 1), 6'd28);
			S_DRV_SQ: begin
				if (alu_done) begin
					sq_q   <= sq_q + alu_res;
					acc_q  <= 64'sd0;
					di_q   <= 2'd0;
					axis_q <= axis_q + 2'd1;
				end
			end
			S_DRV_RT: begin
				// fold the sample into the end sum or the interior lane sums
				if (alu_done) begin
					if (k_q == '0 || k_q == KW'(NSEG))
						ends_q <= ends_q + alu_res;
					else begin
						for (int l = 1; l < ROMBERG_ORDER; l++)
							if ((k_q & KW'((NSEG >> l) - 1)) == '0)
								inner_q[l] <= inner_q[l] + alu_res;
					end
					if (k_q == KW'(NSEG))
						mlast_q <= alu_res;
					else begin
						k_q  <= k_q + KW'(1);
						bk_q <= bk_q + BKW'(b_q);
					end
				end
			end
			S_RB_L0: begin
				if (alu_done) begin
					prev_q[0] <= rnd_shr(alu_res, 6'd1);
					lv_q      <= LW'(1);
				end
			end
			S_RB_LV: begin
				if (alu_done) begin
					last_q <= rnd_shr(alu_res, 6'(lv_q) + 6'd1);
					j_q    <= LW'(1);
				end
			end
			S_RB_J: begin
				if (alu_done) begin
					prev_q[j_q - LW'(1)] <= last_q;
					last_q <= alu_res;
					if (j_q != lv_q)
						j_q <= j_q + LW'(1);
				end
			end
			S_RB_END: begin
				prev_q[lv_q] <= last_q;
				if (!last_lv)
					lv_q <= lv_q + LW'(1);
				else if (phase_q)
					diff_q <= last_q - sfx;
				else begin
					total_q <= last_q;
					if (last_q <= 0) begin
						t_q      <= (dist_q == 19'd0) ? 17'd0 : T_ONE;
						status_q <= (dist_q == 19'd0) ? ST_CONV : ST_SAT;
					end
				end
			end
			S_NT_INIT: begin
				if (alu_done) begin
					t_q     <= cl_nt[16:0];
					sat_q   <= sat_q | cl_nt[17];
					b_q     <= cl_nt[16:0];
					phase_q <= 1'b1;
				end
			end
			S_NT_CHECK: if (conv) status_q <= ST_CONV;
			S_NT_DIV: begin
				if (alu_done) begin
					t_q   <= cl_new[16:0];
					sat_q <= sat_q | cl_new[17];
					if (last_it)
						status_q <= (sat_q | cl_new[17]) ? ST_SAT : ST_LIMIT;
					else begin
						it_q <= it_q + IW'(1);
						b_q  <= cl_new[16:0];
					end
				end
			end
			S_PT_U2: if (alu_done) w0_q <= alu_res;
			S_PT_T2: begin
				if (alu_done) begin
					w2_q <= alu_res;
					pi_q <= 2'd0;
				end
			end
			S_PT_B: begin
				if (alu_done) begin
					blend_q[pi_q] <= rnd_shr(alu_res, 6'd16);
					pi_q          <= pi_q + 2'd1;
					axis_q        <= 2'd0;
					acc_q         <= 64'sd0;
				end
			end
			S_PT_MUL: begin
				if (alu_done) begin
					acc_q <= acc_q + alu_res;
					pi_q  <= pi_q + 2'd1;
				end
			end
			S_PT_AX: begin
				pt_q[axis_q] <= pt_round[20:0];
				acc_q        <= 64'sd0;
				pi_q         <= 2'd0;
				axis_q       <= axis_q + 2'd1;
			end
			default: acc_q <= acc_q;
		endcase
	end

	assign busy    = state_q != S_IDLE;
	assign done    = done_q;
	assign param_t = t_q;
	assign point_x = signed'(pt_q[0]);
	assign point_y = signed'(pt_q[1]);
	assign point_z = signed'(pt_q[2]);
	assign status  = status_q;

	`BDTP_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`BDTP_ASSERT_IMP(a_t_range, clk, arst_n, done, param_t <= T_ONE)
	`BDTP_ASSERT_IMP(a_status_code, clk, arst_n, done, status <= ST_SAT)
	`BDTP_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)

endmodule

`default_nettype wire
